>>> hdl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and codes for the smallest-prime-factor sieve block.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam logic FUNC_BUILD  = 1'b0;
    localparam logic FUNC_FACTOR = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BUILD     = 2'd1;
    localparam logic [1:0] STATUS_ABOVE     = 2'd2;
    localparam logic [1:0] STATUS_NOT_BUILT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PRIME_SQ,
        ST_PRIME_CHK,
        ST_MULT_RD,
        ST_MULT_CHK,
        ST_SINGLE,
        ST_FACT_RD,
        ST_FACT_WAIT,
        ST_DIV,
        ST_DIV_END,
        ST_EMIT
    } spf_state_t;

endpackage

>>> hdl/spf_sieve_factorizer.sv
// ----------------------------------------------------------------------------
// spf_sieve_factorizer
// Smallest-prime-factor table with sieve build and streaming factorizer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes func and number; in_ready is high
// only while no item is in progress. A build item (func 0) initialises the
// table one entry per cycle, then sieves it, reading each multiple visited
// and then writing it if it is still unmarked, and gives one item
// with status build done. A factor item (func 1) gives one item per distinct
// prime: a table read, then the divisions by that prime
// (exponent+1 divisions, 16-step restoring divider), then an emit.
// Numbers 0 and 1, out-of-range numbers and queries before a build give a
// single item. Output items sit in an output register
// (out_valid/out_ready); while it is full and not taken the sequencer waits.
// cfg_we writes sieve_limit; it takes effect at the next build.
// Reset clears the control state and marks the table unbuilt; the table
// memory itself is not cleared, a build writes every entry it will read.
// ----------------------------------------------------------------------------
module spf_sieve_factorizer
    import spf_pkg::*;
#(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [15:0] number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] prime,
    output logic [4:0]  exponent,
    output logic        last,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [31:0] MAX_IDX = 32'(TABLE_DEPTH - 1);

    spf_state_t state_reg, state_next;

    logic [15:0] limit_reg;
    logic [15:0] built_limit_reg, built_limit_next;
    logic        built_reg, built_next;
    logic [15:0] idx_reg, idx_next;
    logic [8:0]  p_reg, p_next;
    logic [16:0] m_reg, m_next;
    logic [15:0] r_reg, r_next;
    logic [15:0] fp_reg, fp_next;
    logic [4:0]  exp_reg, exp_next;
    logic [2:0]  k_reg, k_next;
    logic        first_reg, first_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [1:0]  sstat_reg, sstat_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] prime_reg, prime_next;
    logic [4:0]  exponent_reg, exponent_next;
    logic        last_reg, last_next;
    logic [1:0]  status_reg, status_next;

    logic [15:0] mem [TABLE_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata, mem_rdata;

    logic        in_acc;
    logic        out_free;
    logic        out_load;
    logic [17:0] sq;
    logic        sq_over;
    logic        m_over;
    logic [15:0] clip_lim;
    logic [16:0] shifted;
    logic        ge;
    logic [15:0] rd_clamped;
    logic        emit_last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign sq        = 18'(p_reg) * 18'(p_reg);
    assign sq_over   = sq > {2'b00, built_limit_reg};
    assign m_over    = m_reg > {1'b0, built_limit_reg};
    assign clip_lim  = ({16'h0000, limit_reg} > MAX_IDX) ? MAX_IDX[15:0] : limit_reg;
    assign shifted   = {rem_reg, quo_reg[15]};
    assign ge        = shifted >= {1'b0, fp_reg};
    assign rd_clamped = (mem_rdata < 16'd2 || mem_rdata > r_reg) ? r_reg : mem_rdata;
    assign emit_last = (r_reg <= 16'd1) || (k_reg == 3'd7);

    // table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (func == FUNC_BUILD)
                        state_next = ST_INIT;
                    else if (!built_reg || number > built_limit_reg || number < 16'd2)
                        state_next = ST_SINGLE;
                    else
                        state_next = ST_FACT_RD;
                end
            end
            ST_INIT:
            begin
                if (idx_reg == built_limit_reg)
                    state_next = ST_PRIME_SQ;
            end
            ST_PRIME_SQ:
            begin
                state_next = sq_over ? ST_SINGLE : ST_PRIME_CHK;
            end
            ST_PRIME_CHK:
            begin
                state_next = (mem_rdata == {7'b0, p_reg}) ? ST_MULT_RD : ST_PRIME_SQ;
            end
            ST_MULT_RD:
            begin
                state_next = m_over ? ST_PRIME_SQ : ST_MULT_CHK;
            end
            ST_MULT_CHK:
            begin
                state_next = ST_MULT_RD;
            end
            ST_SINGLE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_FACT_RD:
            begin
                state_next = ST_FACT_WAIT;
            end
            ST_FACT_WAIT:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == 4'd15)
                    state_next = ST_DIV_END;
            end
            ST_DIV_END:
            begin
                if (first_reg || (rem_reg == 16'd0 && r_reg != 16'd0))
                    state_next = ST_DIV;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = emit_last ? ST_IDLE : ST_FACT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        built_limit_next = built_limit_reg;
        built_next       = built_reg;
        idx_next         = idx_reg;
        p_next           = p_reg;
        m_next           = m_reg;
        r_next           = r_reg;
        fp_next          = fp_reg;
        exp_next         = exp_reg;
        k_next           = k_reg;
        first_next       = first_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        sstat_next       = sstat_reg;
        out_load         = 1'b0;
        prime_next       = prime_reg;
        exponent_next    = exponent_reg;
        last_next        = last_reg;
        status_next      = status_reg;
        mem_we           = 1'b0;
        mem_waddr        = AW'(idx_reg);
        mem_wdata        = idx_reg;
        mem_raddr        = AW'(r_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    r_next = number;
                    k_next = 3'd0;
                    if (func == FUNC_BUILD)
                    begin
                        built_limit_next = clip_lim;
                        idx_next         = 16'd0;
                        p_next           = 9'd2;
                    end
                    else if (!built_reg)
                        sstat_next = STATUS_NOT_BUILT;
                    else if (number > built_limit_reg)
                        sstat_next = STATUS_ABOVE;
                    else
                        sstat_next = STATUS_OK;
                end
            end
            ST_INIT:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 16'd1;
            end
            ST_PRIME_SQ:
            begin
                mem_raddr = AW'(p_reg);
                m_next    = sq[16:0];
                if (sq_over)
                begin
                    built_next = 1'b1;
                    sstat_next = STATUS_BUILD;
                end
            end
            ST_PRIME_CHK:
            begin
                if (mem_rdata != {7'b0, p_reg})
                    p_next = p_reg + 9'd1;
            end
            ST_MULT_RD:
            begin
                mem_raddr = AW'(m_reg);
                if (m_over)
                    p_next = p_reg + 9'd1;
            end
            ST_MULT_CHK:
            begin
                mem_waddr = AW'(m_reg);
                mem_wdata = {7'b0, p_reg};
                mem_we    = (mem_rdata == m_reg[15:0]);
                m_next    = m_reg + {8'b0, p_reg};
            end
            ST_SINGLE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    prime_next    = 16'd0;
                    exponent_next = 5'd0;
                    last_next     = 1'b1;
                    status_next   = sstat_reg;
                end
            end
            ST_FACT_RD:
            begin
                mem_raddr = AW'(r_reg);
            end
            ST_FACT_WAIT:
            begin
                fp_next    = rd_clamped;
                quo_next   = r_reg;
                rem_next   = 16'd0;
                cnt_next   = 4'd0;
                first_next = 1'b1;
            end
            ST_DIV:
            begin
                rem_next = ge ? 16'(shifted - {1'b0, fp_reg}) : shifted[15:0];
                quo_next = {quo_reg[14:0], ge};
                cnt_next = cnt_reg + 4'd1;
            end
            ST_DIV_END:
            begin
                if (first_reg || (rem_reg == 16'd0 && r_reg != 16'd0))
                begin
                    r_next     = quo_reg;
                    exp_next   = first_reg ? 5'd1 : exp_reg + 5'd1;
                    first_next = 1'b0;
                    rem_next   = 16'd0;
                    cnt_next   = 4'd0;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    prime_next    = fp_reg;
                    exponent_next = exp_reg;
                    last_next     = emit_last;
                    status_next   = STATUS_OK;
                    k_next        = k_reg + 3'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            limit_reg       <= 16'hFFFF;
            built_limit_reg <= 16'd0;
            built_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
                limit_reg   <= cfg_data;
            built_limit_reg <= built_limit_next;
            built_reg       <= built_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        p_reg        <= p_next;
        m_reg        <= m_next;
        r_reg        <= r_next;
        fp_reg       <= fp_next;
        exp_reg      <= exp_next;
        k_reg        <= k_next;
        first_reg    <= first_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        sstat_reg    <= sstat_next;
        prime_reg    <= prime_next;
        exponent_reg <= exponent_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign prime     = prime_reg;
    assign exponent  = exponent_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    // table writes only while building
    a_write_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_INIT || state_reg == ST_MULT_CHK))
        else $error("table written outside build");

    // divisor never below two
    a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (fp_reg >= 16'd2))
        else $error("divisor below two");

    // factor items carry a non-zero exponent
    a_exponent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && state_reg == ST_EMIT) |-> (exp_reg != 5'd0))
        else $error("factor item with zero exponent");

    // end of sieve marks the table built
    a_built: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRIME_SQ && sq_over) |=> built_reg)
        else $error("table not marked built");

endmodule
